@@ hdl/atta_pkg.sv @@
`default_nettype none
package atta_pkg;

   localparam int CAPACITY_DEFAULT = 1024;

   localparam logic [2:0] MODE_CREATE   = 3'd0;
   localparam logic [2:0] MODE_SET      = 3'd1;
   localparam logic [2:0] MODE_DEDUCE   = 3'd2;
   localparam logic [2:0] MODE_DECAY    = 3'd3;
   localparam logic [2:0] MODE_ALLOCATE = 3'd4;
   localparam logic [2:0] MODE_CLEAR    = 3'd5;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_MISSING = 2'd2;

   localparam logic [15:0] HALF_Q15 = 16'd16384;
   localparam logic [15:0] ONE_Q15  = 16'd32768;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DED_B,
      S_DED_MUL,
      S_ALLOC_WR,
      S_DECAY,
      S_DECAY_LAST,
      S_RESP
   } state_type;

   function automatic logic [15:0] sat_q15(input logic [15:0] v);
      return (v > ONE_Q15) ? ONE_Q15 : v;
   endfunction

endpackage
`default_nettype wire

@@ hdl/atom_truth_attention_table.sv @@
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_stall  | mode, ids, truth values, attention delta
// rsp     | out       | rsp_valid/rsp_stall  | status, created id, products, counts
//
// One item at a time; a finished item waits in the output register while the
// next one is taken. Create, set truth, reset and unused modes go straight to the
// response; allocate reads, then writes attention; deduction makes two reads of the
// truth memory, then the registered multiply; decay walks every atom, if any exist.
// Synchronous reset empties the table and clears the counters; memories keep their
// contents. A stalled result holds and blocks only the next result.
`default_nettype none
module atom_truth_attention_table
   import atta_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_mode,
   input  wire logic [15:0]        req_first_id,
   input  wire logic [15:0]        req_second_id,
   input  wire logic [15:0]        req_new_strength,
   input  wire logic [15:0]        req_new_confidence,
   input  wire logic signed [15:0] req_attention_delta,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [15:0]             rsp_created_id,
   output logic [15:0]             rsp_deduced_strength,
   output logic [15:0]             rsp_deduced_confidence,
   output logic [15:0]             rsp_atom_count,
   output logic [31:0]             rsp_cycle_count,
   output logic [31:0]             rsp_inference_count,
   output logic [31:0]             rsp_allocation_count
);

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic              truth_wr_en;
   logic [ADDR_W-1:0] truth_wr_addr;
   logic [31:0]       truth_wr_data;
   logic [ADDR_W-1:0] truth_rd_addr;
   logic [31:0]       truth_rd_data;
   logic              attn_wr_en;
   logic [ADDR_W-1:0] attn_wr_addr;
   logic [15:0]       attn_wr_data;
   logic [ADDR_W-1:0] attn_rd_addr;
   logic [15:0]       attn_rd_data;
   logic              mul_en;
   logic [15:0]       mul_s_a, mul_s_b, mul_c_a, mul_c_b;
   logic [15:0]       mul_s_product, mul_c_product;

   atta_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_truth (
      .clock   (clock),
      .wr_en   (truth_wr_en),
      .wr_addr (truth_wr_addr),
      .wr_data (truth_wr_data),
      .rd_addr (truth_rd_addr),
      .rd_data (truth_rd_data)
   );

   atta_ram #(.WIDTH(16), .DEPTH(CAPACITY)) u_attn (
      .clock   (clock),
      .wr_en   (attn_wr_en),
      .wr_addr (attn_wr_addr),
      .wr_data (attn_wr_data),
      .rd_addr (attn_rd_addr),
      .rd_data (attn_rd_data)
   );

   atta_mul u_mul_s (
      .clock   (clock),
      .en      (mul_en),
      .a       (mul_s_a),
      .b       (mul_s_b),
      .product (mul_s_product)
   );

   atta_mul u_mul_c (
      .clock   (clock),
      .en      (mul_en),
      .a       (mul_c_a),
      .b       (mul_c_b),
      .product (mul_c_product)
   );

   atta_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_mode               (req_mode),
      .req_first_id           (req_first_id),
      .req_second_id          (req_second_id),
      .req_new_strength       (req_new_strength),
      .req_new_confidence     (req_new_confidence),
      .req_attention_delta    (req_attention_delta),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_created_id         (rsp_created_id),
      .rsp_deduced_strength   (rsp_deduced_strength),
      .rsp_deduced_confidence (rsp_deduced_confidence),
      .rsp_atom_count         (rsp_atom_count),
      .rsp_cycle_count        (rsp_cycle_count),
      .rsp_inference_count    (rsp_inference_count),
      .rsp_allocation_count   (rsp_allocation_count),
      .truth_wr_en            (truth_wr_en),
      .truth_wr_addr          (truth_wr_addr),
      .truth_wr_data          (truth_wr_data),
      .truth_rd_addr          (truth_rd_addr),
      .truth_rd_data          (truth_rd_data),
      .attn_wr_en             (attn_wr_en),
      .attn_wr_addr           (attn_wr_addr),
      .attn_wr_data           (attn_wr_data),
      .attn_rd_addr           (attn_rd_addr),
      .attn_rd_data           (attn_rd_data),
      .mul_en                 (mul_en),
      .mul_s_a                (mul_s_a),
      .mul_s_b                (mul_s_b),
      .mul_c_a                (mul_c_a),
      .mul_c_b                (mul_c_b),
      .mul_s_product          (mul_s_product),
      .mul_c_product          (mul_c_product)
   );

endmodule
`default_nettype wire

@@ hdl/atta_ram.sv @@
`default_nettype none
module atta_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ hdl/atta_mul.sv @@
`default_nettype none
module atta_mul (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [15:0] a,
   input  wire logic [15:0] b,
   output logic      [15:0] product
);

   logic [31:0] full;

   assign full = (32'(a) * 32'(b)) + 32'(16'd16384);

   always_ff @(posedge clock) begin
      if (en) begin
         product <= full[30:15];
      end
   end

endmodule
`default_nettype wire

@@ hdl/atta_ctrl.sv @@
`default_nettype none
module atta_ctrl
   import atta_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT,
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_mode,
   input  wire logic [15:0]        req_first_id,
   input  wire logic [15:0]        req_second_id,
   input  wire logic [15:0]        req_new_strength,
   input  wire logic [15:0]        req_new_confidence,
   input  wire logic signed [15:0] req_attention_delta,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [15:0]             rsp_created_id,
   output logic [15:0]             rsp_deduced_strength,
   output logic [15:0]             rsp_deduced_confidence,
   output logic [15:0]             rsp_atom_count,
   output logic [31:0]             rsp_cycle_count,
   output logic [31:0]             rsp_inference_count,
   output logic [31:0]             rsp_allocation_count,
   output logic                    truth_wr_en,
   output logic [ADDR_W-1:0]       truth_wr_addr,
   output logic [31:0]             truth_wr_data,
   output logic [ADDR_W-1:0]       truth_rd_addr,
   input  wire logic [31:0]        truth_rd_data,
   output logic                    attn_wr_en,
   output logic [ADDR_W-1:0]       attn_wr_addr,
   output logic [15:0]             attn_wr_data,
   output logic [ADDR_W-1:0]       attn_rd_addr,
   input  wire logic [15:0]        attn_rd_data,
   output logic                    mul_en,
   output logic [15:0]             mul_s_a,
   output logic [15:0]             mul_s_b,
   output logic [15:0]             mul_c_a,
   output logic [15:0]             mul_c_b,
   input  wire logic [15:0]        mul_s_product,
   input  wire logic [15:0]        mul_c_product
);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  entry_ff;
   logic [31:0]       cycles_ff;
   logic [31:0]       infer_ff;
   logic [31:0]       alloc_ff;
   logic              pend_ff;
   logic              rsp_valid_ff;

   logic [ADDR_W-1:0] b_idx_ff;
   logic [ADDR_W-1:0] alloc_idx_ff;
   logic [15:0]       delta_ff;
   logic [31:0]       truth_a_ff;
   logic [ADDR_W-1:0] walk_ff;
   logic [ADDR_W-1:0] pend_addr_ff;
   logic [1:0]        status_ff;
   logic [15:0]       created_ff;
   logic              ded_ok_ff;

   logic [1:0]        rsp_status_ff;
   logic [15:0]       rsp_created_ff;
   logic [15:0]       rsp_ded_s_ff;
   logic [15:0]       rsp_ded_c_ff;
   logic [15:0]       rsp_count_ff;
   logic [31:0]       rsp_cycles_ff;
   logic [31:0]       rsp_infer_ff;
   logic [31:0]       rsp_alloc_ff;

   logic              accept;
   logic              out_free;
   logic              a_valid;
   logic              b_valid;
   logic              full;
   logic [ADDR_W-1:0] a_idx;
   logic [ADDR_W-1:0] b_idx;
   logic [ADDR_W-1:0] entry_idx;
   logic [ADDR_W-1:0] last_idx;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign a_valid   = (req_first_id != 16'd0) && (req_first_id <= 16'(entry_ff));
   assign b_valid   = (req_second_id != 16'd0) && (req_second_id <= 16'(entry_ff));
   assign full      = (entry_ff == CNT_W'(CAPACITY));
   assign a_idx     = ADDR_W'(req_first_id - 16'd1);
   assign b_idx     = ADDR_W'(req_second_id - 16'd1);
   assign entry_idx = ADDR_W'(entry_ff);
   assign last_idx  = ADDR_W'(entry_ff - CNT_W'(1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_DEDUCE:   state_in = (a_valid && b_valid) ? S_DED_B : S_RESP;
                  MODE_DECAY:    state_in = (entry_ff != '0) ? S_DECAY : S_RESP;
                  MODE_ALLOCATE: state_in = a_valid ? S_ALLOC_WR : S_RESP;
                  default:       state_in = S_RESP;
               endcase
            end
         end
         S_DED_B:      state_in = S_DED_MUL;
         S_DED_MUL:    state_in = S_RESP;
         S_ALLOC_WR:   state_in = S_RESP;
         S_DECAY: begin
            if (walk_ff == last_idx) begin
               state_in = S_DECAY_LAST;
            end
         end
         S_DECAY_LAST: state_in = S_RESP;
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:      state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_stall     = (state_ff != S_IDLE);
      truth_wr_en   = 1'b0;
      truth_wr_addr = a_idx;
      truth_wr_data = {sat_q15(req_new_strength), sat_q15(req_new_confidence)};
      truth_rd_addr = (state_ff == S_IDLE) ? a_idx : b_idx_ff;
      attn_wr_en    = 1'b0;
      attn_wr_addr  = pend_addr_ff;
      attn_wr_data  = ((attn_rd_data != 16'd0) && !attn_rd_data[15]) ?
                      (attn_rd_data - 16'd1) : attn_rd_data;
      attn_rd_addr  = (state_ff == S_DECAY) ? walk_ff : a_idx;
      mul_en        = (state_ff == S_DED_MUL);
      mul_s_a       = truth_a_ff[31:16];
      mul_s_b       = truth_rd_data[31:16];
      mul_c_a       = truth_a_ff[15:0];
      mul_c_b       = truth_rd_data[15:0];
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_mode == MODE_CREATE) && !full) begin
               truth_wr_en   = 1'b1;
               truth_wr_addr = entry_idx;
               truth_wr_data = {HALF_Q15, HALF_Q15};
               attn_wr_en    = 1'b1;
               attn_wr_addr  = entry_idx;
               attn_wr_data  = 16'd0;
            end else if (accept && (req_mode == MODE_SET) && a_valid) begin
               truth_wr_en = 1'b1;
            end
         end
         S_ALLOC_WR: begin
            attn_wr_en   = 1'b1;
            attn_wr_addr = alloc_idx_ff;
            attn_wr_data = attn_rd_data + delta_ff;
         end
         S_DECAY, S_DECAY_LAST: begin
            attn_wr_en = pend_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         entry_ff     <= '0;
         cycles_ff    <= '0;
         infer_ff     <= '0;
         alloc_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= (state_ff == S_DECAY);
         if (accept) begin
            case (req_mode)
               MODE_CREATE: begin
                  if (!full) begin
                     entry_ff  <= entry_ff + CNT_W'(1);
                     cycles_ff <= cycles_ff + 32'd1;
                  end
               end
               MODE_DECAY: begin
                  cycles_ff <= cycles_ff + 32'd1;
                  alloc_ff  <= alloc_ff + 32'd1;
               end
               MODE_CLEAR: begin
                  entry_ff  <= '0;
                  cycles_ff <= '0;
                  infer_ff  <= '0;
                  alloc_ff  <= '0;
               end
               default: begin
               end
            endcase
         end
         if (state_ff == S_DED_MUL) begin
            infer_ff  <= infer_ff + 32'd1;
            cycles_ff <= cycles_ff + 32'd1;
         end
         if (state_ff == S_ALLOC_WR) begin
            alloc_ff  <= alloc_ff + 32'd1;
            cycles_ff <= cycles_ff + 32'd1;
         end
         if ((state_ff == S_RESP) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_idx_ff     <= b_idx;
         alloc_idx_ff <= a_idx;
         delta_ff     <= req_attention_delta;
         walk_ff      <= '0;
         status_ff    <= STATUS_OK;
         created_ff   <= 16'd0;
         ded_ok_ff    <= 1'b0;
         case (req_mode)
            MODE_CREATE: begin
               if (full) begin
                  status_ff <= STATUS_FULL;
               end else begin
                  created_ff <= 16'(entry_ff) + 16'd1;
               end
            end
            MODE_SET, MODE_ALLOCATE: begin
               if (!a_valid) begin
                  status_ff <= STATUS_MISSING;
               end
            end
            MODE_DEDUCE: begin
               if (!(a_valid && b_valid)) begin
                  status_ff <= STATUS_MISSING;
               end
            end
            default: begin
            end
         endcase
      end
      if (state_ff == S_DED_B) begin
         truth_a_ff <= truth_rd_data;
      end
      if (state_ff == S_DED_MUL) begin
         ded_ok_ff <= 1'b1;
      end
      if (state_ff == S_DECAY) begin
         walk_ff      <= walk_ff + ADDR_W'(1);
         pend_addr_ff <= walk_ff;
      end
      if ((state_ff == S_RESP) && out_free) begin
         rsp_status_ff  <= status_ff;
         rsp_created_ff <= created_ff;
         rsp_ded_s_ff   <= ded_ok_ff ? mul_s_product : 16'd0;
         rsp_ded_c_ff   <= ded_ok_ff ? mul_c_product : 16'd0;
         rsp_count_ff   <= 16'(entry_ff);
         rsp_cycles_ff  <= cycles_ff;
         rsp_infer_ff   <= infer_ff;
         rsp_alloc_ff   <= alloc_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_created_id         = rsp_created_ff;
   assign rsp_deduced_strength   = rsp_ded_s_ff;
   assign rsp_deduced_confidence = rsp_ded_c_ff;
   assign rsp_atom_count         = rsp_count_ff;
   assign rsp_cycle_count        = rsp_cycles_ff;
   assign rsp_inference_count    = rsp_infer_ff;
   assign rsp_allocation_count   = rsp_alloc_ff;

endmodule
`default_nettype wire

@@ hdl/atta_check.sv @@
`default_nettype none
module atta_check
   import atta_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [1:0]         rsp_status,
   input wire logic [15:0]        rsp_created_id,
   input wire logic [15:0]        rsp_deduced_strength,
   input wire logic [15:0]        rsp_deduced_confidence,
   input wire logic [15:0]        rsp_atom_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result item dropped");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |->
         (rsp_created_id == 16'd0) && (rsp_deduced_strength == 16'd0) &&
         (rsp_deduced_confidence == 16'd0))
      else $error("failed item carries data");

   a_q15_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_deduced_strength <= ONE_Q15) &&
                    (rsp_deduced_confidence <= ONE_Q15))
      else $error("deduced value above one");

   a_created_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_created_id != 16'd0) |->
         (rsp_atom_count == rsp_created_id) && (rsp_status == STATUS_OK))
      else $error("created id does not match atom count");

endmodule

bind atom_truth_attention_table atta_check u_check (.*);
`default_nettype wire
